// ===== hdl/mi4_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_pkg
// shared types, scratch memory map, operation codes and cofactor schedule
// tables for the 4x4 single-precision matrix inverse
// ----------------------------------------------------------------------------
package mi4_pkg;

  // word widths and scratch memory geometry
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned RAM_DEPTH = 32;
  localparam int unsigned ADDR_W    = $clog2(RAM_DEPTH);

  // scratch memory map: elements at 0..15, minors from ADDR_MN
  localparam logic [ADDR_W-1:0] ADDR_MN  = 5'd16;
  localparam logic [ADDR_W-1:0] ADDR_T0  = 5'd28;
  localparam logic [ADDR_W-1:0] ADDR_T1  = 5'd29;
  localparam logic [ADDR_W-1:0] ADDR_DET = 5'd30;
  localparam logic [ADDR_W-1:0] ADDR_RC  = 5'd31;

  localparam logic [WORD_W-1:0] FP_ONE   = 32'h3F80_0000;
  localparam logic [WORD_W-1:0] FP_QNAN  = 32'h7FC0_0000;
  localparam logic [3:0]        LAST_IDX = 4'd15;
  localparam logic [3:0]        LAST_MINOR = 4'd11;
  localparam logic [3:0]        DET_LAST_STEP = 4'd10;
  localparam logic [3:0]        ADJ_LAST_STEP = 4'd5;
  localparam logic [3:0]        MINOR_LAST_STEP = 4'd2;

  // floating-point operations
  typedef enum logic [1:0] {
    FOP_MUL = 2'd0,
    FOP_ADD = 2'd1,
    FOP_SUB = 2'd2,
    FOP_DIV = 2'd3
  } fop_e;

  // channel words
  typedef struct packed {
    logic [3:0]  elem_index;
    logic [31:0] elem_bits;
  } mi4_in_t;

  typedef struct packed {
    logic [3:0]  out_index;
    logic [31:0] out_bits;
    logic        singular;
    logic        last_out;
  } mi4_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic              in_load;
    logic [ADDR_W-1:0] ra;
    logic [ADDR_W-1:0] rb;
    logic              start;
    fop_e              op;
    logic              use_one;
    logic              exec;
    logic [ADDR_W-1:0] dst;
    logic              chk_det;
    logic              to_out;
    logic              zero_out;
    logic [3:0]        out_idx;
  } mi4_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic fpu_done;
    logic singular;
  } mi4_status_t;

  // element pairs of each 2x2 minor: e[i]*e[j] - e[k]*e[l]
  typedef struct packed {
    logic [3:0] i;
    logic [3:0] j;
    logic [3:0] k;
    logic [3:0] l;
  } minor_ent_t;

  localparam minor_ent_t MINOR_TAB [12] = '{
    '{4'd0, 4'd5, 4'd1, 4'd4},    '{4'd0, 4'd6, 4'd2, 4'd4},
    '{4'd0, 4'd7, 4'd3, 4'd4},    '{4'd1, 4'd6, 4'd2, 4'd5},
    '{4'd1, 4'd7, 4'd3, 4'd5},    '{4'd2, 4'd7, 4'd3, 4'd6},
    '{4'd8, 4'd13, 4'd9, 4'd12},  '{4'd8, 4'd14, 4'd10, 4'd12},
    '{4'd8, 4'd15, 4'd11, 4'd12}, '{4'd9, 4'd14, 4'd10, 4'd13},
    '{4'd9, 4'd15, 4'd11, 4'd13}, '{4'd10, 4'd15, 4'd11, 4'd14}
  };

  // determinant schedule: one operation per step
  typedef struct packed {
    fop_e              op;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] dst;
  } det_ent_t;

  localparam det_ent_t DET_TAB [11] = '{
    '{FOP_MUL, 5'd16, 5'd27, ADDR_T0},
    '{FOP_MUL, 5'd17, 5'd26, ADDR_T1},
    '{FOP_SUB, ADDR_T0, ADDR_T1, ADDR_DET},
    '{FOP_MUL, 5'd18, 5'd25, ADDR_T1},
    '{FOP_ADD, ADDR_DET, ADDR_T1, ADDR_DET},
    '{FOP_MUL, 5'd19, 5'd24, ADDR_T1},
    '{FOP_ADD, ADDR_DET, ADDR_T1, ADDR_DET},
    '{FOP_MUL, 5'd20, 5'd23, ADDR_T1},
    '{FOP_SUB, ADDR_DET, ADDR_T1, ADDR_DET},
    '{FOP_MUL, 5'd21, 5'd22, ADDR_T1},
    '{FOP_ADD, ADDR_DET, ADDR_T1, ADDR_DET}
  };

  // adjugate terms: three element/minor products, sign of the third
  typedef struct packed {
    logic [3:0] ea;
    logic [3:0] ma;
    logic [3:0] eb;
    logic [3:0] mb;
    logic [3:0] ec;
    logic [3:0] mc;
    logic       add3;
  } adj_ent_t;

  localparam adj_ent_t ADJ_TAB [16] = '{
    '{4'd5,  4'd11, 4'd6,  4'd10, 4'd7,  4'd9, 1'b1},
    '{4'd2,  4'd10, 4'd1,  4'd11, 4'd3,  4'd9, 1'b0},
    '{4'd13, 4'd5,  4'd14, 4'd4,  4'd15, 4'd3, 1'b1},
    '{4'd10, 4'd4,  4'd9,  4'd5,  4'd11, 4'd3, 1'b0},
    '{4'd6,  4'd8,  4'd4,  4'd11, 4'd7,  4'd7, 1'b0},
    '{4'd0,  4'd11, 4'd2,  4'd8,  4'd3,  4'd7, 1'b1},
    '{4'd14, 4'd2,  4'd12, 4'd5,  4'd15, 4'd1, 1'b0},
    '{4'd8,  4'd5,  4'd10, 4'd2,  4'd11, 4'd1, 1'b1},
    '{4'd4,  4'd10, 4'd5,  4'd8,  4'd7,  4'd6, 1'b1},
    '{4'd1,  4'd8,  4'd0,  4'd10, 4'd3,  4'd6, 1'b0},
    '{4'd12, 4'd4,  4'd13, 4'd2,  4'd15, 4'd0, 1'b1},
    '{4'd9,  4'd2,  4'd8,  4'd4,  4'd11, 4'd0, 1'b0},
    '{4'd5,  4'd7,  4'd4,  4'd9,  4'd6,  4'd6, 1'b0},
    '{4'd0,  4'd9,  4'd1,  4'd7,  4'd2,  4'd6, 1'b1},
    '{4'd13, 4'd1,  4'd12, 4'd3,  4'd14, 4'd0, 1'b0},
    '{4'd8,  4'd3,  4'd9,  4'd1,  4'd10, 4'd0, 1'b1}
  };

endpackage

// ===== hdl/mi4_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ram
// generic memory, one write port and two registered read ports
// ----------------------------------------------------------------------------
module mi4_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered reads
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== hdl/mi4_fpu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_fpu
// multi-cycle binary32 unit: multiply, add, subtract, divide, round to
// nearest even, subnormals kept, nan results canonical
// ----------------------------------------------------------------------------
module mi4_fpu
  import mi4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  fop_e        op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  typedef enum logic [8:0] {
    F_IDLE  = 9'b000000001,
    F_MUL   = 9'b000000010,
    F_ALIGN = 9'b000000100,
    F_ADD   = 9'b000001000,
    F_DPRE  = 9'b000010000,
    F_DIV   = 9'b000100000,
    F_NORM  = 9'b001000000,
    F_DEN   = 9'b010000000,
    F_RND   = 9'b100000000
  } fpu_state_e;

  fpu_state_e         state_q, state_d;
  logic               done_q, done_d;
  logic [31:0]        res_q, res_d;
  logic               sgn_q, sgn_d;
  logic               zsgn_q, zsgn_d;
  logic               sub_q, sub_d;
  logic [23:0]        mx_q, mx_d, my_q, my_d;
  logic signed [10:0] ex_q, ex_d, ey_q, ey_d, e_q, e_d;
  logic [49:0]        m_q, m_d;
  logic [24:0]        rem_q, rem_d;
  logic [5:0]         cnt_q, cnt_d;

  // operand unpacking
  logic        sa, sb;
  logic [7:0]  xa, xb;
  logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
  logic [23:0] ma, mb;
  logic signed [10:0] ea, eb;

  assign sa     = a_i[31];
  assign sb     = (op_i == FOP_SUB) ? ~b_i[31] : b_i[31];
  assign xa     = a_i[30:23];
  assign xb     = b_i[30:23];
  assign a_nan  = (xa == 8'hFF) && (a_i[22:0] != 23'd0);
  assign b_nan  = (xb == 8'hFF) && (b_i[22:0] != 23'd0);
  assign a_inf  = (xa == 8'hFF) && (a_i[22:0] == 23'd0);
  assign b_inf  = (xb == 8'hFF) && (b_i[22:0] == 23'd0);
  assign a_zero = (a_i[30:0] == 31'd0);
  assign b_zero = (b_i[30:0] == 31'd0);
  assign ma     = {xa != 8'd0, a_i[22:0]};
  assign mb     = {xb != 8'd0, b_i[22:0]};
  assign ea     = $signed({3'b000, (xa == 8'd0) ? 8'd1 : xa});
  assign eb     = $signed({3'b000, (xb == 8'd0) ? 8'd1 : xb});
  assign a_big  = (a_i[30:0] >= b_i[30:0]);

  // alignment of the smaller addend
  logic signed [10:0] dexp;
  logic [49:0]        yfull, yshift;
  logic               ylost;
  assign dexp   = ex_q - ey_q;
  assign yfull  = {1'b0, my_q, 25'd0};
  assign yshift = (dexp >= 11'sd50) ? 50'd0 : (yfull >> dexp[5:0]);
  assign ylost  = (dexp >= 11'sd50) ? (my_q != 24'd0)
                : ((yfull & ~({50{1'b1}} << dexp[5:0])) != 50'd0);

  // product and division step
  logic [47:0] prod;
  logic        geq;
  logic [24:0] rdiff, rsel;
  assign prod  = mx_q * my_q;
  assign geq   = (rem_q >= {1'b0, my_q});
  assign rdiff = rem_q - {1'b0, my_q};
  assign rsel  = geq ? rdiff : rem_q;

  // subnormal right shift
  logic signed [10:0] dsh;
  logic [49:0]        mden;
  logic               dlost;
  assign dsh   = 11'sd1 - e_q;
  assign mden  = (dsh >= 11'sd50) ? 50'd0 : (m_q >> dsh[5:0]);
  assign dlost = (dsh >= 11'sd50) ? (m_q != 50'd0)
               : ((m_q & ~({50{1'b1}} << dsh[5:0])) != 50'd0);

  // rounding
  logic [24:0]        rsum;
  logic               rup;
  logic [23:0]        rmant;
  logic signed [10:0] re;
  assign rup   = m_q[25] & ((m_q[24:0] != 25'd0) | m_q[26]);
  assign rsum  = {1'b0, m_q[49:26]} + {24'd0, rup};
  assign rmant = rsum[24] ? rsum[24:1] : rsum[23:0];
  assign re    = rsum[24] ? (e_q + 11'sd1) : e_q;

  // next state and datapath
  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    res_d   = res_q;
    sgn_d   = sgn_q;
    zsgn_d  = zsgn_q;
    sub_d   = sub_q;
    mx_d    = mx_q;
    my_d    = my_q;
    ex_d    = ex_q;
    ey_d    = ey_q;
    e_d     = e_q;
    m_d     = m_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    case (state_q)
      F_IDLE: begin
        if (start_i) begin
          sgn_d  = sa ^ sb;
          zsgn_d = sa ^ sb;
          mx_d   = ma;
          my_d   = mb;
          ex_d   = ea;
          ey_d   = eb;
          case (op_i)
            FOP_MUL: begin
              if (a_nan || b_nan || (a_inf && b_zero) || (a_zero && b_inf)) begin
                res_d  = FP_QNAN;
                done_d = 1'b1;
              end else if (a_inf || b_inf) begin
                res_d  = {sa ^ sb, 8'hFF, 23'd0};
                done_d = 1'b1;
              end else begin
                state_d = F_MUL;
              end
            end
            FOP_DIV: begin
              if (a_nan || b_nan || (a_inf && b_inf) || (a_zero && b_zero)) begin
                res_d  = FP_QNAN;
                done_d = 1'b1;
              end else if (a_inf || b_zero) begin
                res_d  = {sa ^ sb, 8'hFF, 23'd0};
                done_d = 1'b1;
              end else if (a_zero || b_inf) begin
                res_d  = {sa ^ sb, 31'd0};
                done_d = 1'b1;
              end else begin
                state_d = F_DPRE;
              end
            end
            default: begin
              zsgn_d = sa & sb;
              sub_d  = sa ^ sb;
              if (a_nan || b_nan || (a_inf && b_inf && (sa != sb))) begin
                res_d  = FP_QNAN;
                done_d = 1'b1;
              end else if (a_inf) begin
                res_d  = {sa, 8'hFF, 23'd0};
                done_d = 1'b1;
              end else if (b_inf) begin
                res_d  = {sb, 8'hFF, 23'd0};
                done_d = 1'b1;
              end else begin
                // larger magnitude goes first
                sgn_d   = a_big ? sa : sb;
                mx_d    = a_big ? ma : mb;
                ex_d    = a_big ? ea : eb;
                my_d    = a_big ? mb : ma;
                ey_d    = a_big ? eb : ea;
                state_d = F_ALIGN;
              end
            end
          endcase
        end
      end
      F_MUL: begin
        m_d     = {prod, 2'b00};
        e_d     = ex_q + ey_q - 11'sd126;
        state_d = F_NORM;
      end
      F_ALIGN: begin
        m_d     = yshift | {49'd0, ylost};
        e_d     = ex_q + 11'sd1;
        state_d = F_ADD;
      end
      F_ADD: begin
        m_d     = sub_q ? ({1'b0, mx_q, 25'd0} - m_q) : ({1'b0, mx_q, 25'd0} + m_q);
        state_d = F_NORM;
      end
      F_DPRE: begin
        // bring subnormal mantissas up to a leading one
        if (!mx_q[23]) begin
          mx_d = {mx_q[22:0], 1'b0};
          ex_d = ex_q - 11'sd1;
        end
        if (!my_q[23]) begin
          my_d = {my_q[22:0], 1'b0};
          ey_d = ey_q - 11'sd1;
        end
        if (mx_q[23] && my_q[23]) begin
          rem_d   = {1'b0, mx_q};
          cnt_d   = 6'd49;
          e_d     = ex_q - ey_q + 11'sd127;
          state_d = F_DIV;
        end
      end
      F_DIV: begin
        // one quotient bit per cycle, remainder jammed into the last bit
        rem_d = {rsel[23:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          m_d     = {m_q[48:0], geq | (rsel != 25'd0)};
          state_d = F_NORM;
        end else begin
          m_d = {m_q[48:0], geq};
        end
      end
      F_NORM: begin
        if (m_q == 50'd0) begin
          res_d   = {zsgn_q, 31'd0};
          done_d  = 1'b1;
          state_d = F_IDLE;
        end else if (!m_q[49] && (e_q > 11'sd1)) begin
          if ((m_q[49:42] == 8'd0) && (e_q > 11'sd8)) begin
            m_d = {m_q[41:0], 8'd0};
            e_d = e_q - 11'sd8;
          end else begin
            m_d = {m_q[48:0], 1'b0};
            e_d = e_q - 11'sd1;
          end
        end else begin
          state_d = F_DEN;
        end
      end
      F_DEN: begin
        if (e_q < 11'sd1) begin
          m_d = mden | {49'd0, dlost};
          e_d = 11'sd1;
        end
        state_d = F_RND;
      end
      F_RND: begin
        if (re >= 11'sd255) begin
          res_d = {sgn_q, 8'hFF, 23'd0};
        end else if (!rmant[23]) begin
          res_d = {sgn_q, 8'd0, rmant[22:0]};
        end else begin
          res_d = {sgn_q, re[7:0], rmant[22:0]};
        end
        done_d  = 1'b1;
        state_d = F_IDLE;
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    sgn_q  <= sgn_d;
    zsgn_q <= zsgn_d;
    sub_q  <= sub_d;
    mx_q   <= mx_d;
    my_q   <= my_d;
    ex_q   <= ex_d;
    ey_q   <= ey_d;
    e_q    <= e_d;
    m_q    <= m_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== hdl/mi4_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_datapath
// scratch memory, shared floating-point unit, singular flag and output word
// ----------------------------------------------------------------------------
module mi4_datapath
  import mi4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mi4_in_t     in_word_i,
  input  mi4_cmd_t    cmd_i,
  output mi4_status_t status_o,
  output mi4_out_t    out_word_o
);

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [WORD_W-1:0] wdata, rdata_a, rdata_b, fpu_a, fpu_res;
  logic              fpu_done, res_done;
  logic              singular_q;
  mi4_out_t          out_q;

  // write mux: incoming element or unit result
  assign res_done = cmd_i.exec & fpu_done;
  assign we       = cmd_i.in_load | (res_done & ~cmd_i.to_out);
  assign waddr    = cmd_i.in_load ? {1'b0, in_word_i.elem_index} : cmd_i.dst;
  assign wdata    = cmd_i.in_load ? in_word_i.elem_bits : fpu_res;

  mi4_ram #(
    .WIDTH (WORD_W),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (cmd_i.ra),
    .raddr_b_i (cmd_i.rb),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  assign fpu_a = cmd_i.use_one ? FP_ONE : rdata_a;

  mi4_fpu u_fpu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.start),
    .op_i    (cmd_i.op),
    .a_i     (fpu_a),
    .b_i     (rdata_b),
    .done_o  (fpu_done),
    .res_o   (fpu_res)
  );

  // singular flag from the finished determinant
  always_ff @(posedge clk_i) begin
    if (res_done && cmd_i.chk_det) begin
      singular_q <= (fpu_res[30:0] == 31'd0);
    end
  end

  // output word register
  always_ff @(posedge clk_i) begin
    if (res_done && cmd_i.to_out) begin
      out_q <= '{out_index: cmd_i.out_idx, out_bits: fpu_res, singular: singular_q,
                 last_out: (cmd_i.out_idx == LAST_IDX)};
    end else if (cmd_i.zero_out) begin
      out_q <= '{out_index: cmd_i.out_idx, out_bits: '0, singular: singular_q,
                 last_out: (cmd_i.out_idx == LAST_IDX)};
    end
  end

  assign status_o   = '{fpu_done: fpu_done, singular: singular_q};
  assign out_word_o = out_q;

endmodule

// ===== hdl/mi4_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi4_ctrl
// sequencer: element loading, minor/determinant/reciprocal/adjugate schedule,
// output handshake
// ----------------------------------------------------------------------------
module mi4_ctrl
  import mi4_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [3:0]  in_index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  mi4_status_t status_i,
  output mi4_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_START = 4'b0100,
    S_EXEC  = 4'b1000
  } ctrl_state_e;

  typedef enum logic [4:0] {
    PH_MINOR = 5'b00001,
    PH_DET   = 5'b00010,
    PH_DIV   = 5'b00100,
    PH_ADJ   = 5'b01000,
    PH_ZERO  = 5'b10000
  } phase_e;

  ctrl_state_e state_q;
  phase_e      phase_q;
  logic [3:0]  k_q, step_q;
  logic        out_valid_q;

  // operation decode for the current step
  minor_ent_t        mt;
  det_ent_t          dt;
  adj_ent_t          at;
  fop_e              op;
  logic [ADDR_W-1:0] ra, rb, dst;
  logic              use_one, chk_det, to_out;

  always_comb begin
    mt      = (k_q <= LAST_MINOR) ? MINOR_TAB[k_q] : '0;
    dt      = (step_q <= DET_LAST_STEP) ? DET_TAB[step_q] : '0;
    at      = ADJ_TAB[k_q];
    op      = FOP_MUL;
    ra      = ADDR_T0;
    rb      = ADDR_T1;
    dst     = ADDR_T0;
    use_one = 1'b0;
    chk_det = 1'b0;
    to_out  = 1'b0;
    case (phase_q)
      PH_MINOR: begin
        case (step_q)
          4'd0: begin
            ra = {1'b0, mt.i};
            rb = {1'b0, mt.j};
          end
          4'd1: begin
            ra  = {1'b0, mt.k};
            rb  = {1'b0, mt.l};
            dst = ADDR_T1;
          end
          default: begin
            op  = FOP_SUB;
            dst = ADDR_MN + {1'b0, k_q};
          end
        endcase
      end
      PH_DET: begin
        op      = dt.op;
        ra      = dt.a;
        rb      = dt.b;
        dst     = dt.dst;
        chk_det = (step_q == DET_LAST_STEP);
      end
      PH_DIV: begin
        op      = FOP_DIV;
        use_one = 1'b1;
        rb      = ADDR_DET;
        dst     = ADDR_RC;
      end
      PH_ADJ: begin
        case (step_q)
          4'd0: begin
            ra = {1'b0, at.ea};
            rb = ADDR_MN + {1'b0, at.ma};
          end
          4'd1: begin
            ra  = {1'b0, at.eb};
            rb  = ADDR_MN + {1'b0, at.mb};
            dst = ADDR_T1;
          end
          4'd2: begin
            op = FOP_SUB;
          end
          4'd3: begin
            ra  = {1'b0, at.ec};
            rb  = ADDR_MN + {1'b0, at.mc};
            dst = ADDR_T1;
          end
          4'd4: begin
            op = at.add3 ? FOP_ADD : FOP_SUB;
          end
          default: begin
            rb     = ADDR_RC;
            to_out = 1'b1;
          end
        endcase
      end
      default: begin
        op = FOP_MUL;
      end
    endcase
  end

  logic in_acc, zero_load, res_done;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign zero_load  = (state_q == S_RD) && (phase_q == PH_ZERO) && !out_valid_q;
  assign res_done   = (state_q == S_EXEC) && status_i.fpu_done;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_MINOR;
      k_q     <= 4'd0;
      step_q  <= 4'd0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_acc && (in_index_i == LAST_IDX)) begin
            phase_q <= PH_MINOR;
            k_q     <= 4'd0;
            step_q  <= 4'd0;
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (phase_q == PH_ZERO) begin
            if (zero_load) begin
              k_q <= k_q + 4'd1;
              if (k_q == LAST_IDX) begin
                state_q <= S_IDLE;
              end
            end
          end else if (!(to_out && out_valid_q)) begin
            state_q <= S_START;
          end
        end
        S_START: begin
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (status_i.fpu_done) begin
            case (phase_q)
              PH_MINOR: begin
                state_q <= S_RD;
                if (step_q == MINOR_LAST_STEP) begin
                  step_q <= 4'd0;
                  if (k_q == LAST_MINOR) begin
                    k_q     <= 4'd0;
                    phase_q <= PH_DET;
                  end else begin
                    k_q <= k_q + 4'd1;
                  end
                end else begin
                  step_q <= step_q + 4'd1;
                end
              end
              PH_DET: begin
                state_q <= S_RD;
                if (step_q == DET_LAST_STEP) begin
                  step_q  <= 4'd0;
                  phase_q <= PH_DIV;
                end else begin
                  step_q <= step_q + 4'd1;
                end
              end
              PH_DIV: begin
                state_q <= S_RD;
                step_q  <= 4'd0;
                k_q     <= 4'd0;
                phase_q <= status_i.singular ? PH_ZERO : PH_ADJ;
              end
              default: begin
                if (step_q == ADJ_LAST_STEP) begin
                  step_q  <= 4'd0;
                  k_q     <= k_q + 4'd1;
                  state_q <= (k_q == LAST_IDX) ? S_IDLE : S_RD;
                end else begin
                  step_q  <= step_q + 4'd1;
                  state_q <= S_RD;
                end
              end
            endcase
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (zero_load || (res_done && to_out)) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  assign cmd_o = '{
    in_load:  in_acc,
    ra:       ra,
    rb:       rb,
    start:    (state_q == S_START),
    op:       op,
    use_one:  use_one,
    exec:     (state_q == S_EXEC),
    dst:      dst,
    chk_det:  chk_det,
    to_out:   to_out,
    zero_out: zero_load,
    out_idx:  k_q
  };

endmodule

// ===== hdl/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_inverse_4x4
// 4x4 binary32 matrix inverse by cofactors, one shared floating-point unit
// ----------------------------------------------------------------------------
// Elements are loaded one word per cycle while no run is in flight, each with
// its storage index; the word with index 15 starts an inversion of the
// current contents (all sixteen must have been written since reset). The run
// then executes 144 floating-point operations on a nonsingular matrix, one at
// a time on a single shared multi-cycle unit; the one divide forms the
// reciprocal of the determinant. Sixteen result words follow in storage
// order, the sixteenth marked with last_out; a zero determinant skips the
// adjugate terms and gives zero results with the singular flag. No input is
// taken while a run is in flight.
// ----------------------------------------------------------------------------
module matrix_inverse_4x4
  import mi4_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mi4_in_t  in_word_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mi4_out_t out_word_o
);

  mi4_cmd_t    cmd;
  mi4_status_t status;

  // sequencer
  mi4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_index_i  (in_word_i.elem_index),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  mi4_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule
